// ----- src/aof_pkg.sv -----
package aof_pkg;

    // transaction selector codes
    localparam logic [1:0] FUNC_CLR = 2'd0;
    localparam logic [1:0] FUNC_ADD = 2'd1;
    localparam logic [1:0] FUNC_RD  = 2'd2;

    // field widths
    localparam int COORD_W = 24;
    localparam int SIZE_W  = 20;
    localparam int EDGE_W  = 26;
    localparam int ENT_W   = 8;

    localparam int DEF_MAX_BOXES = 256;

    // token that walks down the cell chain
    typedef struct packed {
        logic [1:0]               op;
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic signed [EDGE_W-1:0] top;
        logic                     act;
        logic                     hit;
        logic                     ovf;
    } t_box;

endpackage

// ----- src/aof_front.sv -----
module aof_front #(
    parameter int MAX_BOXES = aof_pkg::DEF_MAX_BOXES,
    parameter int IW        = $clog2(MAX_BOXES + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic                               i_acc,
    input  logic [1:0]                         i_func,
    input  logic signed [aof_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [aof_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [aof_pkg::COORD_W-1:0] i_off_x,
    input  logic signed [aof_pkg::COORD_W-1:0] i_off_y,
    input  logic [aof_pkg::SIZE_W-1:0]         i_box_width,
    input  logic [aof_pkg::SIZE_W-1:0]         i_box_height,
    input  logic                               i_active,
    input  logic [aof_pkg::ENT_W-1:0]          i_entity,
    output aof_pkg::t_box                      o_tok,
    output logic                               o_vld,
    output logic [IW-1:0]                      o_idx
);
    import aof_pkg::*;

    localparam int CW = ((IW > ENT_W) ? IW : ENT_W) + 1;
    localparam logic [IW-1:0] FULL_CNT = IW'(MAX_BOXES);

    logic [IW-1:0] r_cnt, n_cnt;
    logic          r_full, n_full;

    // first stage: sums of position and offset
    logic                      r_a_vld, n_a_vld;
    logic [1:0]                r_a_op, n_a_op;
    logic [IW-1:0]             r_a_idx, n_a_idx;
    logic signed [COORD_W:0]   r_a_l, r_a_b;
    logic [SIZE_W-1:0]         r_a_w, r_a_h;
    logic                      r_a_act, r_a_ovf;

    // second stage: finished token
    logic                      r_b_vld;
    t_box                      r_b_tok, n_b_tok;
    logic [IW-1:0]             r_b_idx;

    logic                      w_rd_ok;

    assign w_rd_ok = (CW'(i_entity) < CW'(r_cnt));

    // frame bookkeeping and op decode
    always_comb begin
        n_cnt   = r_cnt;
        n_full  = r_full;
        n_a_vld = 1'b0;
        n_a_op  = i_func;
        n_a_idx = r_cnt;
        case (i_func)
            FUNC_CLR: begin
                n_cnt   = '0;
                n_full  = 1'b0;
                n_a_vld = 1'b1;
            end
            FUNC_ADD: begin
                if (r_cnt >= FULL_CNT) begin
                    n_full = 1'b1;
                end else begin
                    n_a_vld = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            FUNC_RD: begin
                n_a_vld = 1'b1;
                // out-of-range index matches no cell, so hit reads back as zero
                n_a_idx = w_rd_ok ? IW'(i_entity) : FULL_CNT;
            end
            default: begin
                n_a_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_full  <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_adv) begin
            r_a_vld <= i_acc & n_a_vld;
            r_b_vld <= r_a_vld;
            if (i_acc) begin
                r_cnt  <= n_cnt;
                r_full <= n_full;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_op  <= n_a_op;
            r_a_idx <= n_a_idx;
            r_a_l   <= {i_pos_x[COORD_W-1], i_pos_x} + {i_off_x[COORD_W-1], i_off_x};
            r_a_b   <= {i_pos_y[COORD_W-1], i_pos_y} + {i_off_y[COORD_W-1], i_off_y};
            r_a_w   <= i_box_width;
            r_a_h   <= i_box_height;
            r_a_act <= i_active;
            r_a_ovf <= r_full;
            r_b_tok <= n_b_tok;
            r_b_idx <= r_a_idx;
        end
    end

    // right and top edges
    always_comb begin
        n_b_tok        = '0;
        n_b_tok.op     = r_a_op;
        n_b_tok.left   = {r_a_l[COORD_W], r_a_l};
        n_b_tok.bottom = {r_a_b[COORD_W], r_a_b};
        n_b_tok.right  = {r_a_l[COORD_W], r_a_l} + {{(EDGE_W-SIZE_W){1'b0}}, r_a_w};
        n_b_tok.top    = {r_a_b[COORD_W], r_a_b} + {{(EDGE_W-SIZE_W){1'b0}}, r_a_h};
        n_b_tok.act    = r_a_act;
        n_b_tok.hit    = 1'b0;
        n_b_tok.ovf    = r_a_ovf;
    end

    assign o_tok = r_b_tok;
    assign o_vld = r_b_vld;
    assign o_idx = r_b_idx;

endmodule

// ----- src/aof_cell.sv -----
module aof_cell #(
    parameter int IW  = $clog2(aof_pkg::DEF_MAX_BOXES + 1),
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  aof_pkg::t_box i_tok,
    input  logic          i_vld,
    input  logic [IW-1:0] i_idx,
    output aof_pkg::t_box o_tok,
    output logic          o_vld,
    output logic [IW-1:0] o_idx
);
    import aof_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    // stored box
    logic signed [EDGE_W-1:0] r_l, r_r, r_b, r_t;
    logic                     r_act, n_act;
    logic                     r_hit, n_hit;
    logic                     w_store;

    // token register toward the next cell
    t_box                     r_tok, n_tok;
    logic                     r_vld;
    logic [IW-1:0]            r_idx;

    logic                     w_ovl;
    logic                     w_cmp;

    assign w_ovl = (r_l < i_tok.right) && (r_r > i_tok.left) &&
                   (r_b < i_tok.top) && (r_t > i_tok.bottom);

    // a later add compares against this box
    assign w_cmp = i_vld && (i_tok.op == FUNC_ADD) && (i_idx > MY_IDX) &&
                   r_act && i_tok.act && w_ovl;

    assign w_store = i_vld && (i_tok.op == FUNC_ADD) && (i_idx == MY_IDX);

    always_comb begin
        n_act = r_act;
        n_hit = r_hit;
        n_tok = i_tok;
        case (i_tok.op)
            FUNC_CLR: begin
                if (i_vld) begin
                    n_act = 1'b0;
                    n_hit = 1'b0;
                end
            end
            FUNC_ADD: begin
                if (w_store) begin
                    n_act = i_tok.act;
                    n_hit = i_tok.hit;
                end
                if (w_cmp) begin
                    n_hit     = 1'b1;
                    n_tok.hit = 1'b1;
                end
            end
            FUNC_RD: begin
                if (i_idx == MY_IDX) begin
                    n_tok.hit = r_hit;
                end
            end
            default: begin
                n_tok = i_tok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_hit <= 1'b0;
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_act <= n_act;
            r_hit <= n_hit;
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
            r_idx <= i_idx;
            if (w_store) begin
                r_l <= i_tok.left;
                r_r <= i_tok.right;
                r_b <= i_tok.bottom;
                r_t <= i_tok.top;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_vld = r_vld;
    assign o_idx = r_idx;

endmodule

// ----- src/aabb_overlap_flagger_core.sv -----
// Overlap flagger for one frame of axis-aligned boxes.
// Input channel: i_valid / o_stall with i_func selecting the transaction:
//   clear frame, add box (position, offset, width, height, active) or read
//   the hit flag of i_entity. Output channel: o_valid / i_stall carrying
//   o_hit and the sticky o_overflow, one result per read only.
// Each stored box lives in one cell of a chain of MAX_BOXES cells. Every
// transaction walks down the chain one cell per cycle unless the chain holds:
// an add is compared with each earlier active box on its way and is written
// into its own cell, a read picks up the flag at its cell, a clear empties
// every cell it passes. Throughput: one transaction per cycle while the
// chain does not hold, set by the chain being fully pipelined. A read passes
// the front's sum and edge stages, the cell chain and the output register.
// Reset empties the frame and drops all transactions in flight.
// While a result waits in the output register and i_stall is high, the
// whole chain holds and o_stall is raised; otherwise inputs keep flowing.
module aabb_overlap_flagger_core #(
    parameter int MAX_BOXES = aof_pkg::DEF_MAX_BOXES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_func,
    input  logic signed [aof_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [aof_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [aof_pkg::COORD_W-1:0] i_off_x,
    input  logic signed [aof_pkg::COORD_W-1:0] i_off_y,
    input  logic [aof_pkg::SIZE_W-1:0]         i_box_width,
    input  logic [aof_pkg::SIZE_W-1:0]         i_box_height,
    input  logic                               i_active,
    input  logic [aof_pkg::ENT_W-1:0]          i_entity,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_hit,
    output logic                               o_overflow
);
    import aof_pkg::*;

    localparam int IW = $clog2(MAX_BOXES + 1);

    logic          w_adv;
    t_box          w_tok [0:MAX_BOXES];
    logic          w_vld [0:MAX_BOXES];
    logic [IW-1:0] w_idx [0:MAX_BOXES];

    logic          r_out_vld;
    logic          r_out_hit;
    logic          r_out_ovf;

    // chain moves unless a result is held back by the receiver
    assign w_adv   = !(r_out_vld && i_stall);
    assign o_stall = !w_adv;

    aof_front #(
        .MAX_BOXES (MAX_BOXES),
        .IW        (IW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_acc        (i_valid),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_off_x      (i_off_x),
        .i_off_y      (i_off_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_active     (i_active),
        .i_entity     (i_entity),
        .o_tok        (w_tok[0]),
        .o_vld        (w_vld[0]),
        .o_idx        (w_idx[0])
    );

    // one cell per stored box
    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
        aof_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .i_vld   (w_vld[g]),
            .i_idx   (w_idx[g]),
            .o_tok   (w_tok[g+1]),
            .o_vld   (w_vld[g+1]),
            .o_idx   (w_idx[g+1])
        );
    end

    // result register, loaded by reads leaving the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_vld[MAX_BOXES] && (w_tok[MAX_BOXES].op == FUNC_RD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_hit <= w_tok[MAX_BOXES].hit;
            r_out_ovf <= w_tok[MAX_BOXES].ovf;
        end
    end

    // last index is not needed past the chain
    logic w_unused_idx;
    assign w_unused_idx = ^w_idx[MAX_BOXES];

    assign o_valid    = r_out_vld;
    assign o_hit      = r_out_hit & (w_unused_idx | 1'b1);
    assign o_overflow = r_out_ovf;

endmodule
